[src/tssf_pkg.sv]
// Shared types, constants and digit functions for the temperature seven-segment formatter.
`timescale 1ns / 1ps
`default_nettype none
package tssf_pkg;

    localparam int WORD_W   = 16;
    localparam int WHOLE_W  = 7;
    localparam int SEG_W    = 8;
    localparam int SEL_W    = 4;
    localparam int DIGITS   = 4;
    localparam int IDX_W    = 2;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 8;
    localparam int OUT_DATA_W = 16;

    // Config register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_LOW  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ALARM_HIGH = 8'd1;

    localparam logic [WHOLE_W-1:0] ALARM_LOW_RST  = 7'd20;
    localparam logic [WHOLE_W-1:0] ALARM_HIGH_RST = 7'd30;

    // Digit slot order on the output: half, ones, tens, sign
    localparam logic [IDX_W-1:0] SLOT_HALF = 2'd0;
    localparam logic [IDX_W-1:0] SLOT_ONES = 2'd1;
    localparam logic [IDX_W-1:0] SLOT_TENS = 2'd2;
    localparam logic [IDX_W-1:0] SLOT_SIGN = 2'd3;

    // Glyph codes beyond 0..9
    localparam logic [3:0] CODE_BLANK = 4'd10;
    localparam logic [3:0] CODE_MINUS = 4'd11;

    localparam logic [SEG_W-1:0] SEG_DP = 8'h80;

    // Reciprocal of 10 for 7-bit values: q = (x * 205) >> 11
    localparam logic [7:0] RECIP10 = 8'd205;
    localparam int RECIP10_SH = 11;

    typedef logic [SEG_W-1:0] seg_t;

    typedef struct packed {
        seg_t [DIGITS-1:0] seg;        // indexed by slot
        logic              out_of_band;
    } digits_t;

    function automatic seg_t seg_of(input logic [3:0] code);
        seg_t s;
        unique case (code)
            4'd0:       s = 8'h3F;
            4'd1:       s = 8'h06;
            4'd2:       s = 8'h5B;
            4'd3:       s = 8'h4F;
            4'd4:       s = 8'h66;
            4'd5:       s = 8'h6D;
            4'd6:       s = 8'h7C;
            4'd7:       s = 8'h07;
            4'd8:       s = 8'h7F;
            4'd9:       s = 8'h67;
            CODE_MINUS: s = 8'h40;
            default:    s = 8'h00;
        endcase
        return s;
    endfunction

endpackage
`default_nettype wire

[src/tssf_digits.sv]
// Decodes one temperature word into four segment patterns and the alarm band check.
`timescale 1ns / 1ps
`default_nettype none
module tssf_digits
(
    input  wire logic [tssf_pkg::WORD_W-1:0]  word,
    input  wire logic [tssf_pkg::WHOLE_W-1:0] alarm_low,
    input  wire logic [tssf_pkg::WHOLE_W-1:0] alarm_high,
    output tssf_pkg::digits_t                 digits
);
    import tssf_pkg::*;

    logic [WORD_W-1:0]  mag;
    logic [WHOLE_W-1:0] whole;
    logic [14:0]        prod;
    logic [3:0]         quot;
    logic [3:0]         tens;
    logic [3:0]         ones;
    logic [6:0]         quot_x10;

    always_comb
    begin
        // 0x8000 negates to itself, giving minus zero
        mag   = word[WORD_W-1] ? (~word + 16'd1) : word;
        whole = mag[14:8];

        prod     = 15'(whole) * 15'(RECIP10);
        quot     = prod[RECIP10_SH +: 4];           // whole / 10, 0..12
        tens     = (quot >= 4'd10) ? (quot - 4'd10) : quot;
        quot_x10 = 7'(quot) * 7'd10;
        ones     = 4'(whole - quot_x10);

        digits.seg[SLOT_HALF] = seg_of(mag[7] ? 4'd5 : 4'd0);
        digits.seg[SLOT_ONES] = seg_of(ones) | SEG_DP;
        digits.seg[SLOT_TENS] = seg_of(tens);
        digits.seg[SLOT_SIGN] = seg_of(word[WORD_W-1] ? CODE_MINUS : CODE_BLANK);

        digits.out_of_band = (whole >= alarm_high) || (whole < alarm_low);
    end

endmodule
`default_nettype wire

[src/temperature_seven_segment_formatter.sv]
// Top level: temperature reading in, four seven-segment digit results out.
// A reading passes through the input register and then the serializer register before its first digit appears;
// each reading is sent as four digit beats over the single output channel, and the input
// register accepts the next reading while the current run is still going out.
// Reset (rst_n low, async): buffers empty, buzzer off, alarm band 20..29.
`timescale 1ns / 1ps
`default_nettype none
module temperature_seven_segment_formatter
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // reading request in
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    input  wire logic [tssf_pkg::WORD_W-1:0]       s_tdata,   // [15:0] temperature_word
    // digit results out
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    output logic [tssf_pkg::OUT_DATA_W-1:0]        m_tdata,   // [7:0] segments, [8] buzzer_on
    output logic [tssf_pkg::SEL_W-1:0]             m_tuser,   // [3:0] digit_select
    output logic                                   m_tlast,   // last_digit
    // config write channel
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [tssf_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tssf_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import tssf_pkg::*;

    // Input register
    logic              in_valid_reg, in_valid_next;
    logic [WORD_W-1:0] in_word_reg, in_word_next;

    // Output serializer: four decoded patterns, walked by slot index
    logic                   ser_valid_reg, ser_valid_next;
    logic [IDX_W-1:0]       idx_reg, idx_next;
    seg_t [DIGITS-1:0]      ser_seg_reg, ser_seg_next;
    logic                   buzzer_reg, buzzer_next;

    logic [WHOLE_W-1:0]     alarm_low_reg, alarm_low_next;
    logic [WHOLE_W-1:0]     alarm_high_reg, alarm_high_next;

    digits_t                digits;
    logic                   in_accept;
    logic                   out_accept;
    logic                   run_done;
    logic                   load;

    tssf_digits u_digits
    (
        .word       (in_word_reg),
        .alarm_low  (alarm_low_reg),
        .alarm_high (alarm_high_reg),
        .digits     (digits)
    );

    always_comb
    begin
        cfg_ready  = 1'b1;
        out_accept = m_tvalid && m_tready;
        run_done   = out_accept && (idx_reg == SLOT_SIGN);
        // serializer takes a new reading when empty or finishing its last beat
        load       = in_valid_reg && (!ser_valid_reg || run_done);
        s_tready   = !in_valid_reg || load;
        in_accept  = s_tvalid && s_tready;

        in_valid_next = in_accept ? 1'b1 : (load ? 1'b0 : in_valid_reg);
        in_word_next  = in_accept ? s_tdata : in_word_reg;

        ser_valid_next = ser_valid_reg;
        idx_next       = idx_reg;
        ser_seg_next   = ser_seg_reg;
        buzzer_next    = buzzer_reg;
        if (load)
        begin
            ser_valid_next = 1'b1;
            idx_next       = SLOT_HALF;
            ser_seg_next   = digits.seg;
            buzzer_next    = buzzer_reg ^ digits.out_of_band;
        end
        else if (run_done)
        begin
            ser_valid_next = 1'b0;
            idx_next       = SLOT_HALF;
        end
        else if (out_accept)
        begin
            idx_next = idx_reg + 2'd1;
        end

        alarm_low_next  = alarm_low_reg;
        alarm_high_next = alarm_high_reg;
        if (cfg_valid && cfg_ready)
        begin
            // only the low 7 bits are kept; unknown indexes are dropped
            if (cfg_index == REG_ALARM_LOW)
                alarm_low_next = cfg_data[WHOLE_W-1:0];
            else if (cfg_index == REG_ALARM_HIGH)
                alarm_high_next = cfg_data[WHOLE_W-1:0];
        end

        m_tvalid = ser_valid_reg;
        m_tdata  = {7'd0, buzzer_reg, ser_seg_reg[idx_reg]};
        m_tuser  = SEL_W'(1) << idx_reg;
        m_tlast  = (idx_reg == SLOT_SIGN);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            ser_valid_reg  <= 1'b0;
            idx_reg        <= SLOT_HALF;
            buzzer_reg     <= 1'b0;
            alarm_low_reg  <= ALARM_LOW_RST;
            alarm_high_reg <= ALARM_HIGH_RST;
        end
        else
        begin
            in_valid_reg   <= in_valid_next;
            ser_valid_reg  <= ser_valid_next;
            idx_reg        <= idx_next;
            buzzer_reg     <= buzzer_next;
            alarm_low_reg  <= alarm_low_next;
            alarm_high_reg <= alarm_high_next;
        end
    end

    // payload, no reset needed
    always_ff @(posedge clk)
    begin
        in_word_reg <= in_word_next;
        ser_seg_reg <= ser_seg_next;
    end

    // a run in progress never drops out of valid mid-way
    a_run_valid: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != SLOT_HALF) |-> m_tvalid)
        else $error("slot index advanced with serializer empty");

    // a full input register is only overwritten when its reading moves on
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_valid_reg) |-> load)
        else $error("input register overwritten");

    // the buzzer only changes when a new reading enters the serializer
    a_buzzer_load: assert property (@(posedge clk) disable iff (!rst_n)
        !load |=> $stable(buzzer_reg))
        else $error("buzzer changed without a new reading");

    // a finished run is followed by the half digit or an empty serializer
    a_run_restart: assert property (@(posedge clk) disable iff (!rst_n)
        run_done |=> (idx_reg == SLOT_HALF))
        else $error("run did not restart at half digit");

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the temperature seven-segment formatter: predicts and checks each digit request.
`timescale 1ns / 1ps
module tb_top;
    import tssf_pkg::*;

    // One-hot digit enables, in output order
    localparam logic [SEL_W-1:0] SEL_HALF = 4'b0001;
    localparam logic [SEL_W-1:0] SEL_ONES = 4'b0010;
    localparam logic [SEL_W-1:0] SEL_TENS = 4'b0100;
    localparam logic [SEL_W-1:0] SEL_SIGN = 4'b1000;

    localparam int STALL_LIMIT = 1000;  // cycles with no request moving anywhere
    localparam int HOLD_CYCLES = 48;    // long output back-pressure stretch
    localparam int SETTLE_CYCLES = 4;   // quiet wait after the last queued digit has arrived

    typedef struct packed {
        seg_t             seg;
        logic [SEL_W-1:0] sel;
        logic             buzz;
        logic             last;
    } digit_t;

    // Mirrors the alarm band and buzzer bit, queues the four digits of each reading.
    class digit_scoreboard;
        logic [WHOLE_W-1:0] alarm_lo;
        logic [WHOLE_W-1:0] alarm_hi;
        logic               buzzer;
        digit_t             expected_digits[$];
        int                 mismatches;

        function new();
            alarm_lo   = ALARM_LOW_RST;
            alarm_hi   = ALARM_HIGH_RST;
            buzzer     = 1'b0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            // only 7 bits are kept; unknown indexes are dropped
            if (idx == REG_ALARM_LOW)
                alarm_lo = data[WHOLE_W-1:0];
            else if (idx == REG_ALARM_HIGH)
                alarm_hi = data[WHOLE_W-1:0];
        endfunction

        function seg_t glyph(int unsigned code);
            case (code)
                0:          return 8'h3F;
                1:          return 8'h06;
                2:          return 8'h5B;
                3:          return 8'h4F;
                4:          return 8'h66;
                5:          return 8'h6D;
                6:          return 8'h7C;
                7:          return 8'h07;
                8:          return 8'h7F;
                9:          return 8'h67;
                CODE_MINUS: return 8'h40;
                default:    return 8'h00;
            endcase
        endfunction

        function void push_digit(seg_t seg, logic [SEL_W-1:0] sel, logic last);
            digit_t d;
            d.seg  = seg;
            d.sel  = sel;
            d.buzz = buzzer;
            d.last = last;
            expected_digits.push_back(d);
        endfunction

        function void note_reading(logic [WORD_W-1:0] raw);
            logic [WORD_W-1:0]  mag;
            logic [WHOLE_W-1:0] whole;
            int unsigned        tens;
            int unsigned        ones;
            seg_t               sign_seg;
            mag      = raw;
            sign_seg = glyph(CODE_BLANK);
            if (raw[WORD_W-1])
            begin
                // 0x8000 negates to itself and reads as minus zero
                mag      = ~raw + 16'd1;
                sign_seg = glyph(CODE_MINUS);
            end
            whole = mag[14:8];
            tens  = (whole / 10) % 10;  // hundreds digit is dropped
            ones  = whole % 10;
            // band test as written: an inverted band toggles on every reading
            if (whole >= alarm_hi || whole < alarm_lo)
                buzzer = ~buzzer;
            push_digit(glyph(mag[7] ? 5 : 0), SEL_HALF, 1'b0);
            push_digit(glyph(ones) | SEG_DP, SEL_ONES, 1'b0);
            push_digit(glyph(tens), SEL_TENS, 1'b0);
            push_digit(sign_seg, SEL_SIGN, 1'b1);
        endfunction

        function void check_digit(seg_t seg, logic [SEL_W-1:0] sel, logic buzz, logic last);
            digit_t got;
            digit_t exp_d;
            got.seg  = seg;
            got.sel  = sel;
            got.buzz = buzz;
            got.last = last;
            if (expected_digits.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("MISMATCH: unexpected digit seg=%02h sel=%h buz=%b last=%b",
                             seg, sel, buzz, last);
                return;
            end
            exp_d = expected_digits.pop_front();
            if (got.seg !== exp_d.seg || got.sel !== exp_d.sel ||
                got.buzz !== exp_d.buzz || got.last !== exp_d.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display({"MISMATCH: exp seg=%02h sel=%h buz=%b last=%b, ",
                              "got seg=%02h sel=%h buz=%b last=%b"},
                             exp_d.seg, exp_d.sel, exp_d.buzz, exp_d.last,
                             seg, sel, buzz, last);
            end
        endfunction

        function int outstanding();
            return expected_digits.size();
        endfunction

        function void flush_check();
            if (expected_digits.size() != 0)
            begin
                mismatches += expected_digits.size();
                $display("MISMATCH: %0d digits never arrived", expected_digits.size());
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [WORD_W-1:0]      s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;
    logic [SEL_W-1:0]       m_tuser;
    logic                   m_tlast;
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    digit_scoreboard sb = new();

    int src_idle_pct = 0;
    int snk_idle_pct = 0;
    int hold_requests = 0;  // bumped by the stimulus to ask for a long stall
    int hold_served = 0;
    int hold_left = 0;

    temperature_seven_segment_formatter i_dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Output side: random back-pressure, plus a long hold when asked
    always @(negedge clk)
    begin
        if (hold_served != hold_requests)
        begin
            hold_served = hold_requests;
            hold_left   = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
    end

    // Monitor: readings are noted before digits are checked at the same edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_tvalid && s_tready)
                sb.note_reading(s_tdata);
            if (m_tvalid && m_tready)
                sb.check_digit(m_tdata[SEG_W-1:0], m_tuser, m_tdata[SEG_W], m_tlast);
        end
    end

    initial
    begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)
                || !rst_n)
                quiet = 0;
            else
                quiet++;
        end
        $display("tb: failure");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the request is taken.
    task automatic send_reading(input logic [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= WORD_W'($urandom);
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
        sb.set_reg(idx, data);
        @(negedge clk);
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    // Drop valid, wait for every queued digit, then let the pipe go quiet.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.outstanding() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Mix of fully random words and readings that sit on the alarm band edges.
    function automatic logic [WORD_W-1:0] random_reading();
        logic [WHOLE_W-1:0] whole;
        logic [WORD_W-1:0]  w;
        if ($urandom_range(0, 1) == 0)
            return WORD_W'($urandom);
        case ($urandom_range(0, 4))
            0:       whole = sb.alarm_lo - 7'd1;
            1:       whole = sb.alarm_lo;
            2:       whole = sb.alarm_hi - 7'd1;
            3:       whole = sb.alarm_hi;
            default: whole = WHOLE_W'($urandom);
        endcase
        w = {1'b0, whole, 8'($urandom)};
        if ($urandom_range(0, 1) == 1)
            w = ~w + 16'd1;
        return w;
    endfunction

    task automatic run_phase(input int n, input int src_pct, input int snk_pct, input bit squeeze);
        src_idle_pct = src_pct;
        snk_idle_pct = snk_pct;
        if (squeeze)
            hold_requests++;
        repeat (n) send_reading(random_reading());
        settle();
    endtask

    initial
    begin
        logic [WORD_W-1:0] directed_readings [];
        directed_readings = '{
            16'h0000, 16'h0080, 16'h7F80, 16'h7F00, 16'h8000, 16'hFFFF,
            16'hFF80, 16'h8080, 16'h8100, 16'h6400, 16'h6E80, 16'h1300,
            16'h1400, 16'h1D80, 16'h1E00, 16'h197F, 16'hE700, 16'h0900,
            16'h0A00, 16'h3F00, 16'h5580, 16'h2A55
        };
        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        m_tready  = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Reset band 20..29: edges of the word, minus zero, 3-digit values, band edges
        src_idle_pct = 30;
        snk_idle_pct = 61;
        foreach (directed_readings[i])
            send_reading(directed_readings[i]);
        settle();

        // Widest band; top data bit must be dropped; unknown indexes ignored
        write_reg(REG_ALARM_LOW, 8'h80);
        write_reg(REG_ALARM_HIGH, 8'hFF);
        write_reg(8'd2, 8'($urandom));
        write_reg(8'hFF, 8'($urandom));
        run_phase(33, 30, 61, 1'b0);

        // Inverted band, with a long output stall to fill the block
        write_reg(REG_ALARM_LOW, 8'h7F);
        write_reg(REG_ALARM_HIGH, 8'h80);
        run_phase(33, 30, 61, 1'b1);

        write_reg(REG_ALARM_LOW, 8'($urandom));
        write_reg(REG_ALARM_HIGH, 8'($urandom));
        run_phase(33, 61, 30, 1'b0);

        // Zero-width band at the top
        write_reg(REG_ALARM_LOW, 8'd127);
        write_reg(REG_ALARM_HIGH, 8'd127);
        run_phase(33, 61, 30, 1'b0);

        write_reg(REG_ALARM_LOW, 8'($urandom));
        write_reg(REG_ALARM_HIGH, 8'($urandom));
        run_phase(33, 0, 0, 1'b1);

        write_reg(REG_ALARM_LOW, {1'b0, ALARM_LOW_RST});
        write_reg(REG_ALARM_HIGH, {1'b0, ALARM_HIGH_RST});
        run_phase(33, 0, 0, 1'b0);

        repeat (8) @(posedge clk);
        sb.flush_check();
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
